// File: sv/pei_pkg.sv
// Package for the polyline edge intersection block: default sizes, register
// indexes, product slots, and side and vertex codes.
// No dependencies; every other file uses it by scoped names.
package pei_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int BOX_MARGIN_DEF  = 1;

    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_START_X = 3'd0,
        REG_EDGE_START_Y = 3'd1,
        REG_EDGE_END_X   = 3'd2,
        REG_EDGE_END_Y   = 3'd3,
        REG_SNAP_ENABLE  = 3'd4,
        REG_TOLERANCE    = 3'd5
    } t_cfg_reg;

    // Slots of the shared multiplier's products, in issue order.
    localparam int PR_SIDE_Y = 0;
    localparam int PR_SIDE_X = 1;
    localparam int PR_PAR_A  = 2;
    localparam int PR_PAR_B  = 3;
    localparam int PR_NUM_A  = 4;
    localparam int PR_NUM_B  = 5;
    localparam int PR_NL     = 6;
    localparam int PR_LO     = 7;
    localparam int PR_HI     = 8;
    localparam int PR_LIM    = 9;
    localparam int PR_NEAR_S = 10;
    localparam int PR_NEAR_E = 11;
    localparam int NUM_PROD  = 12;

    localparam logic [1:0] SIDE_ON  = 2'd0;
    localparam logic [1:0] SIDE_POS = 2'd1;
    localparam logic [1:0] SIDE_NEG = 2'd2;

    localparam logic [1:0] VFLAG_NONE  = 2'b00;
    localparam logic [1:0] VFLAG_START = 2'b01;
    localparam logic [1:0] VFLAG_END   = 2'b10;

endpackage

// File: sv/pei_if.sv
// Handshake interfaces of the polyline edge intersection block: trail point
// input, result output and register write channel. Depends on pei_pkg.
interface pei_in_if #(
    parameter int COORD_WIDTH = pei_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          first_point;
    logic                          last_point;

    modport source (output valid, point_x, point_y, first_point, last_point, input ready);
    modport sink   (input valid, point_x, point_y, first_point, last_point, output ready);
endinterface

interface pei_out_if;
    logic                          valid;
    logic                          ready;
    logic [pei_pkg::FRAC_W-1:0]    cut_fraction;
    logic                          start_vertex_hit;
    logic                          end_vertex_hit;

    modport source (output valid, cut_fraction, start_vertex_hit, end_vertex_hit,
                    input ready);
    modport sink   (input valid, cut_fraction, start_vertex_hit, end_vertex_hit,
                    output ready);
endinterface

interface pei_cfg_if #(
    parameter int COORD_WIDTH = pei_pkg::COORD_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [pei_pkg::CFG_IDX_W-1:0]   index;
    logic [COORD_WIDTH-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/polyline_edge_intersect.sv
// Polyline edge intersection: finds where a streamed trail first crosses one
// configured edge. Depends on pei_pkg and the interfaces in pei_if.sv.
//
// Usage: write the edge vertices, snap enable and tolerance through i_cfg
// (always ready, one register per item, index as in the register list) while
// the block is idle. Trail points then arrive on i_in; first_point starts a
// new trail, last_point asks for a result, which leaves on o_out.
// Each point is worked through twelve products on one shared shift-add
// multiplier, each after an operand setup step (ST_SETUP, then ST_MUL),
// plus the states that form and test the terms (ST_ND1 to ST_ND3, ST_PAR,
// ST_DEC) and, when a fraction is needed, a restoring divider (ST_PREP,
// ST_DIV).
// One point is in work at a time; i_in.ready is high only while idle.
// The result sits in an output register; the next point is accepted while it
// waits. A last point whose result meets a still-full output register holds
// in its final cycle until o_out.ready frees it.
// Reset clears the edge registers to zero, enables snapping with zero
// tolerance, and clears the trail state and the output valid.
module polyline_edge_intersect #(
    parameter int COORD_WIDTH = pei_pkg::COORD_WIDTH_DEF,
    parameter int BOX_MARGIN  = pei_pkg::BOX_MARGIN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pei_cfg_if.sink      i_cfg,
    pei_in_if.sink       i_in,
    pei_out_if.source    o_out
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int BW     = CW + 3;
    localparam int PW     = CW + 3;
    localparam int WW     = 3 * CW + 8;
    localparam int MC_W   = $clog2(BW);
    localparam int PIDX_W = $clog2(pei_pkg::NUM_PROD);
    localparam int QW     = pei_pkg::FRAC_W;
    localparam int DCNT_W = $clog2(pei_pkg::FRAC_BITS + 1);
    localparam logic [MC_W-1:0]   MC_LAST  = MC_W'(BW - 1);
    localparam logic [DCNT_W-1:0] DCNT_END = DCNT_W'(pei_pkg::FRAC_BITS);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_SETUP = 11'b000_0000_0010,
        ST_MUL   = 11'b000_0000_0100,
        ST_ND1   = 11'b000_0000_1000,
        ST_ND2   = 11'b000_0001_0000,
        ST_ND3   = 11'b000_0010_0000,
        ST_PAR   = 11'b000_0100_0000,
        ST_DEC   = 11'b000_1000_0000,
        ST_PREP  = 11'b001_0000_0000,
        ST_DIV   = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    // Configuration.
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by;
    logic                 r_snap;
    logic [7:0]           r_tol;

    // Trail state.
    logic signed [CW-1:0] r_px, r_py;
    logic [1:0]           r_pside;
    logic                 r_cross;
    logic [QW-1:0]        r_ffrac;
    logic [1:0]           r_fflags;
    logic [1:0]           r_exact;

    // Current item.
    logic signed [CW-1:0] r_x, r_y;
    logic                 r_first, r_last;
    logic [1:0]           r_cur;

    // Shared multiplier.
    logic signed [WW-1:0] r_acc, r_ma;
    logic [BW-1:0]        r_mb;
    logic [MC_W-1:0]      r_mcnt;
    logic [PIDX_W-1:0]    r_pidx;
    logic signed [WW-1:0] r_prod [pei_pkg::NUM_PROD];

    // Intersection terms and divider.
    logic signed [WW-1:0] r_n, r_d, r_absn, r_dmn;
    logic signed [PW-1:0] r_xi2, r_yi2;
    logic signed [WW-1:0] r_dn, r_dd, r_rem;
    logic [QW-1:0]        r_q;
    logic [DCNT_W-1:0]    r_dcnt;

    // Output register.
    logic                 r_ovalid;
    logic [QW-1:0]        r_ofrac;
    logic                 r_os, r_oe;

    logic                 n_in_acc;
    logic [1:0]           n_exact;

    // Differences.
    logic signed [DW-1:0] w_dx2, w_dy2, w_dx1, w_dy1;
    logic signed [DW-1:0] w_xax, w_yay, w_pxax, w_pyay, w_bxx;
    logic signed [CW+1:0] w_adx, w_ady;
    logic signed [BW-1:0] w_len;
    logic signed [WW-1:0] w_opa;
    logic signed [BW-1:0] w_opb;
    logic signed [WW-1:0] w_madd, w_msum;

    assign w_dx2  = DW'(r_bx) - DW'(r_ax);
    assign w_dy2  = DW'(r_by) - DW'(r_ay);
    assign w_dx1  = DW'(r_x) - DW'(r_px);
    assign w_dy1  = DW'(r_y) - DW'(r_py);
    assign w_xax  = DW'(r_x) - DW'(r_ax);
    assign w_yay  = DW'(r_y) - DW'(r_ay);
    assign w_pxax = DW'(r_px) - DW'(r_ax);
    assign w_pyay = DW'(r_py) - DW'(r_ay);
    assign w_bxx  = DW'(r_bx) - DW'(r_x);
    assign w_adx  = w_dx2[DW-1] ? -(CW+2)'(w_dx2) : (CW+2)'(w_dx2);
    assign w_ady  = w_dy2[DW-1] ? -(CW+2)'(w_dy2) : (CW+2)'(w_dy2);
    assign w_len  = (w_adx < w_ady) ? BW'(w_ady) : BW'(w_adx);

    // Operands of the product in the current slot.
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_pidx)
            PIDX_W'(pei_pkg::PR_SIDE_Y): begin
                w_opa = WW'(w_dx2);
                w_opb = BW'(w_yay);
            end
            PIDX_W'(pei_pkg::PR_SIDE_X): begin
                w_opa = WW'(w_dy2);
                w_opb = BW'(w_xax);
            end
            PIDX_W'(pei_pkg::PR_PAR_A): begin
                w_opa = WW'(w_dy1);
                w_opb = BW'(w_dx2);
            end
            PIDX_W'(pei_pkg::PR_PAR_B): begin
                w_opa = WW'(w_dy2);
                w_opb = BW'(w_dx1);
            end
            PIDX_W'(pei_pkg::PR_NUM_A): begin
                w_opa = WW'(w_pxax);
                w_opb = BW'(w_dy1);
            end
            PIDX_W'(pei_pkg::PR_NUM_B): begin
                w_opa = WW'(w_pyay);
                w_opb = BW'(w_dx1);
            end
            PIDX_W'(pei_pkg::PR_NL): begin
                w_opa = r_n;
                w_opb = w_len;
            end
            PIDX_W'(pei_pkg::PR_LO): begin
                w_opa = r_d;
                w_opb = BW'(-BOX_MARGIN);
            end
            PIDX_W'(pei_pkg::PR_HI): begin
                w_opa = r_d;
                w_opb = w_len + BW'(BOX_MARGIN);
            end
            PIDX_W'(pei_pkg::PR_LIM): begin
                w_opa = r_d;
                w_opb = BW'(r_tol);
            end
            PIDX_W'(pei_pkg::PR_NEAR_S): begin
                w_opa = r_absn;
                w_opb = w_len;
            end
            PIDX_W'(pei_pkg::PR_NEAR_E): begin
                w_opa = r_dmn[WW-1] ? -r_dmn : r_dmn;
                w_opb = w_len;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // The multiplier's top bit carries negative weight.
    assign w_madd = r_mb[0] ? ((r_mcnt == MC_LAST) ? -r_ma : r_ma) : '0;
    assign w_msum = r_acc + w_madd;

    // Side of the current point.
    logic signed [WW-1:0] w_c;
    logic [1:0]           w_sraw, w_cur, w_prev;
    logic                 w_test;

    assign w_c = r_prod[pei_pkg::PR_SIDE_Y] - r_prod[pei_pkg::PR_SIDE_X];

    always_comb begin
        if (w_dx2 == '0) begin
            if (w_bxx == '0) begin
                w_cur = pei_pkg::SIDE_ON;
            end else if (w_bxx[DW-1]) begin
                w_cur = pei_pkg::SIDE_NEG;
            end else begin
                w_cur = pei_pkg::SIDE_POS;
            end
            w_sraw = w_cur;
        end else begin
            if (w_c == '0) begin
                w_sraw = pei_pkg::SIDE_ON;
            end else if (w_c[WW-1]) begin
                w_sraw = pei_pkg::SIDE_NEG;
            end else begin
                w_sraw = pei_pkg::SIDE_POS;
            end
            // A leftward edge flips the sense of the cross product.
            if (w_dx2[DW-1] && w_sraw == pei_pkg::SIDE_POS) begin
                w_cur = pei_pkg::SIDE_NEG;
            end else if (w_dx2[DW-1] && w_sraw == pei_pkg::SIDE_NEG) begin
                w_cur = pei_pkg::SIDE_POS;
            end else begin
                w_cur = w_sraw;
            end
        end
    end

    assign w_prev = r_first ? w_cur : r_pside;
    assign w_test = !r_cross && (w_prev == pei_pkg::SIDE_ON || w_cur == pei_pkg::SIDE_ON
                                 || w_prev != w_cur);

    logic w_zero_edge, w_par;
    assign w_zero_edge = (w_dx2 == '0) && (w_dy2 == '0);
    assign w_par = ((w_dx1 == '0) && (w_dx2 == '0)) ||
                   ((w_dx1 != '0) && (w_dx2 != '0) &&
                    (r_prod[pei_pkg::PR_PAR_A] == r_prod[pei_pkg::PR_PAR_B]));

    // Parallel case: midpoint of the box overlap, doubled.
    logic signed [CW-1:0] w_exmn, w_exmx, w_eymn, w_eymx;
    logic signed [CW-1:0] w_pxmn, w_pxmx, w_pymn, w_pymx;
    logic signed [CW+1:0] w_xlo, w_xhi, w_ylo, w_yhi;
    logic signed [CW+1:0] w_tx1, w_tx2, w_ty1, w_ty2;

    assign w_exmn = (r_ax < r_bx) ? r_ax : r_bx;
    assign w_exmx = (r_ax > r_bx) ? r_ax : r_bx;
    assign w_eymn = (r_ay < r_by) ? r_ay : r_by;
    assign w_eymx = (r_ay > r_by) ? r_ay : r_by;
    assign w_pxmn = (r_px < r_x) ? r_px : r_x;
    assign w_pxmx = (r_px > r_x) ? r_px : r_x;
    assign w_pymn = (r_py < r_y) ? r_py : r_y;
    assign w_pymx = (r_py > r_y) ? r_py : r_y;
    assign w_xlo  = (CW+2)'(w_exmn) - (CW+2)'(BOX_MARGIN);
    assign w_xhi  = (CW+2)'(w_exmx) + (CW+2)'(BOX_MARGIN);
    assign w_ylo  = (CW+2)'(w_eymn) - (CW+2)'(BOX_MARGIN);
    assign w_yhi  = (CW+2)'(w_eymx) + (CW+2)'(BOX_MARGIN);
    assign w_tx1  = (w_xhi < (CW+2)'(w_pxmx)) ? w_xhi : (CW+2)'(w_pxmx);
    assign w_tx2  = (w_xlo > (CW+2)'(w_pxmn)) ? w_xlo : (CW+2)'(w_pxmn);
    assign w_ty1  = (w_yhi < (CW+2)'(w_pymx)) ? w_yhi : (CW+2)'(w_pymx);
    assign w_ty2  = (w_ylo > (CW+2)'(w_pymn)) ? w_ylo : (CW+2)'(w_pymn);

    logic                 w_out_box;
    logic signed [PW:0]   w_sdx, w_sdy, w_edx, w_edy, w_tol2;
    logic signed [PW:0]   w_asdx, w_asdy, w_aedx, w_aedy;
    logic signed [PW:0]   w_pnum, w_pden;
    logic                 w_pnear_s, w_pnear_e;

    assign w_out_box = (r_xi2 < (PW'(w_xlo) <<< 1)) || (r_xi2 > (PW'(w_xhi) <<< 1)) ||
                       (r_yi2 < (PW'(w_ylo) <<< 1)) || (r_yi2 > (PW'(w_yhi) <<< 1));
    assign w_sdx  = (PW+1)'(r_xi2) - ((PW+1)'(r_ax) <<< 1);
    assign w_sdy  = (PW+1)'(r_yi2) - ((PW+1)'(r_ay) <<< 1);
    assign w_edx  = (PW+1)'(r_xi2) - ((PW+1)'(r_bx) <<< 1);
    assign w_edy  = (PW+1)'(r_yi2) - ((PW+1)'(r_by) <<< 1);
    assign w_asdx = w_sdx[PW] ? -w_sdx : w_sdx;
    assign w_asdy = w_sdy[PW] ? -w_sdy : w_sdy;
    assign w_aedx = w_edx[PW] ? -w_edx : w_edx;
    assign w_aedy = w_edy[PW] ? -w_edy : w_edy;
    assign w_tol2 = (PW+1)'({r_tol, 1'b0});
    assign w_pnear_s = (w_asdx <= w_tol2) && (w_asdy <= w_tol2);
    assign w_pnear_e = (w_aedx <= w_tol2) && (w_aedy <= w_tol2);
    assign w_pnum = (w_ady <= w_adx) ? w_sdx : w_sdy;
    assign w_pden = (w_ady <= w_adx) ? ((PW+1)'(w_dx2) <<< 1) : ((PW+1)'(w_dy2) <<< 1);

    // General case: box test and vertex proximity on scaled products.
    logic w_nl_fail, w_lim_s, w_lim_e;
    assign w_nl_fail = (r_prod[pei_pkg::PR_NL] < r_prod[pei_pkg::PR_LO]) ||
                       (r_prod[pei_pkg::PR_HI] < r_prod[pei_pkg::PR_NL]);
    assign w_lim_s   = !(r_prod[pei_pkg::PR_LIM] < r_prod[pei_pkg::PR_NEAR_S]);
    assign w_lim_e   = !(r_prod[pei_pkg::PR_LIM] < r_prod[pei_pkg::PR_NEAR_E]);

    // Divider step.
    logic signed [WW-1:0] w_rem2;
    logic                 w_ge;
    assign w_rem2 = r_rem <<< 1;
    assign w_ge   = !(w_rem2 < r_dd);

    assign n_in_acc = i_in.valid && i_in.ready;

    always_comb begin
        n_exact = r_first ? pei_pkg::VFLAG_NONE : r_exact;
        if (i_in.first_point) begin
            n_exact = pei_pkg::VFLAG_NONE;
        end else begin
            n_exact = r_exact;
        end
        if (n_exact == pei_pkg::VFLAG_NONE) begin
            if (i_in.point_x == r_ax && i_in.point_y == r_ay) begin
                n_exact = pei_pkg::VFLAG_START;
            end else if (i_in.point_x == r_bx && i_in.point_y == r_by) begin
                n_exact = pei_pkg::VFLAG_END;
            end
        end
    end

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_ovalid;
    assign o_out.cut_fraction     = r_ofrac;
    assign o_out.start_vertex_hit = r_os;
    assign o_out.end_vertex_hit   = r_oe;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax   <= '0;
            r_ay   <= '0;
            r_bx   <= '0;
            r_by   <= '0;
            r_snap <= 1'b1;
            r_tol  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (pei_pkg::t_cfg_reg'(i_cfg.index))
                pei_pkg::REG_EDGE_START_X: r_ax <= i_cfg.data;
                pei_pkg::REG_EDGE_START_Y: r_ay <= i_cfg.data;
                pei_pkg::REG_EDGE_END_X:   r_bx <= i_cfg.data;
                pei_pkg::REG_EDGE_END_Y:   r_by <= i_cfg.data;
                pei_pkg::REG_SNAP_ENABLE:  r_snap <= i_cfg.data[0];
                pei_pkg::REG_TOLERANCE:    r_tol <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (n_in_acc) begin
                    r_x     <= i_in.point_x;
                    r_y     <= i_in.point_y;
                    r_first <= i_in.first_point;
                    r_last  <= i_in.last_point;
                end
            end
            ST_SETUP: begin
                r_acc  <= '0;
                r_ma   <= w_opa;
                r_mb   <= w_opb;
                r_mcnt <= '0;
            end
            ST_MUL: begin
                if (r_mcnt == MC_LAST) begin
                    r_prod[r_pidx] <= w_msum;
                end else begin
                    r_acc  <= w_msum;
                    r_ma   <= r_ma <<< 1;
                    r_mb   <= r_mb >> 1;
                    r_mcnt <= r_mcnt + 1'b1;
                end
            end
            ST_ND1: begin
                if (w_dx1 == '0) begin
                    r_n <= WW'(w_xax);
                    r_d <= WW'(w_dx2);
                end else begin
                    r_n <= r_prod[pei_pkg::PR_NUM_A] - r_prod[pei_pkg::PR_NUM_B];
                    r_d <= r_prod[pei_pkg::PR_PAR_A] - r_prod[pei_pkg::PR_PAR_B];
                end
            end
            ST_ND2: begin
                if (r_d[WW-1]) begin
                    r_n <= -r_n;
                    r_d <= -r_d;
                end
            end
            ST_ND3: begin
                r_absn <= r_n[WW-1] ? -r_n : r_n;
                r_dmn  <= r_d - r_n;
            end
            ST_PAR: begin
                r_xi2 <= PW'(w_tx1) + PW'(w_tx2);
                r_yi2 <= PW'(w_ty1) + PW'(w_ty2);
            end
            ST_DEC: begin
                r_cur <= w_cur;
                if (w_par) begin
                    r_dn <= w_pden[PW] ? -WW'(w_pnum) : WW'(w_pnum);
                    r_dd <= w_pden[PW] ? -WW'(w_pden) : WW'(w_pden);
                end else begin
                    r_dn <= r_n;
                    r_dd <= r_d;
                end
            end
            ST_PREP: begin
                r_rem  <= r_dn;
                r_q    <= '0;
                r_dcnt <= '0;
            end
            ST_DIV: begin
                if (r_dcnt != DCNT_END) begin
                    r_rem  <= w_ge ? (w_rem2 - r_dd) : w_rem2;
                    r_q    <= {r_q[QW-2:0], w_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer and trail state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pidx   <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_pside  <= pei_pkg::SIDE_ON;
            r_cross  <= 1'b0;
            r_ffrac  <= '0;
            r_fflags <= pei_pkg::VFLAG_NONE;
            r_exact  <= pei_pkg::VFLAG_NONE;
            r_ovalid <= 1'b0;
        end else begin
            // A result loaded in the final cycle replaces the one leaving.
            if (o_out.valid && o_out.ready && !(r_state == ST_FIN && r_last)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_in_acc) begin
                        r_exact <= n_exact;
                        r_pidx  <= '0;
                        if (i_in.first_point) begin
                            r_px     <= i_in.point_x;
                            r_py     <= i_in.point_y;
                            r_cross  <= 1'b0;
                            r_ffrac  <= '0;
                            r_fflags <= pei_pkg::VFLAG_NONE;
                        end
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_mcnt == MC_LAST) begin
                        r_pidx <= r_pidx + 1'b1;
                        if (r_pidx == PIDX_W'(pei_pkg::PR_NUM_B)) begin
                            r_state <= ST_ND1;
                        end else if (r_pidx == PIDX_W'(pei_pkg::NUM_PROD - 1)) begin
                            r_state <= ST_PAR;
                        end else begin
                            r_state <= ST_SETUP;
                        end
                    end
                end
                ST_ND1: begin
                    r_state <= ST_ND2;
                end
                ST_ND2: begin
                    r_state <= ST_ND3;
                end
                ST_ND3: begin
                    r_state <= ST_SETUP;
                end
                ST_PAR: begin
                    r_state <= ST_DEC;
                end
                ST_DEC: begin
                    r_state <= ST_FIN;
                    if (w_test && !w_zero_edge) begin
                        if (w_par) begin
                            if (!w_out_box) begin
                                if (r_snap && w_pnear_s) begin
                                    r_cross  <= 1'b1;
                                    r_ffrac  <= '0;
                                    r_fflags <= pei_pkg::VFLAG_START;
                                end else if (r_snap && w_pnear_e) begin
                                    r_cross  <= 1'b1;
                                    r_ffrac  <= '0;
                                    r_fflags <= pei_pkg::VFLAG_END;
                                end else begin
                                    r_state <= ST_PREP;
                                end
                            end
                        end else if (!w_nl_fail) begin
                            if (r_snap && w_lim_s) begin
                                r_cross  <= 1'b1;
                                r_ffrac  <= '0;
                                r_fflags <= pei_pkg::VFLAG_START;
                            end else if (r_snap && w_lim_e) begin
                                r_cross  <= 1'b1;
                                r_ffrac  <= '0;
                                r_fflags <= pei_pkg::VFLAG_END;
                            end else begin
                                r_state <= ST_PREP;
                            end
                        end
                    end
                end
                ST_PREP: begin
                    r_cross  <= 1'b1;
                    r_fflags <= pei_pkg::VFLAG_NONE;
                    if (r_dd[WW-1] || r_dd == '0 || r_dn[WW-1] || r_dn == '0) begin
                        r_ffrac <= '0;
                        r_state <= ST_FIN;
                    end else if (!(r_dn < r_dd)) begin
                        r_ffrac <= pei_pkg::FRAC_ONE;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_dcnt == DCNT_END) begin
                        // Round half up on the final remainder.
                        r_ffrac <= r_q + QW'(w_ge);
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_last || !r_ovalid || o_out.ready) begin
                        r_px    <= r_x;
                        r_py    <= r_y;
                        r_pside <= r_cur;
                        if (r_last) begin
                            r_ovalid <= 1'b1;
                            if (r_snap && r_exact != pei_pkg::VFLAG_NONE) begin
                                r_ofrac <= '0;
                                r_os    <= r_exact[0];
                                r_oe    <= r_exact[1];
                            end else if (r_cross) begin
                                r_ofrac <= r_ffrac;
                                r_os    <= r_fflags[0];
                                r_oe    <= r_fflags[1];
                            end else begin
                                r_ofrac <= '0;
                                r_os    <= 1'b0;
                                r_oe    <= 1'b0;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/pei_checker.sv
// Port-level checker for the polyline edge intersection block, bound to the
// top level. Depends on pei_pkg and polyline_edge_intersect.
module pei_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pei_pkg::FRAC_W-1:0]  i_frac,
    input logic                        i_start_hit,
    input logic                        i_end_hit
);

    // A point occupies the sequencer, so input ready drops after each accepted point.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frac) &&
        $stable(i_start_hit) && $stable(i_end_hit))
        else $error("stalled result changed");

    a_one_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_start_hit && i_end_hit))
        else $error("both vertex flags set");

    a_frac_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frac != '0 |-> !i_start_hit && !i_end_hit)
        else $error("fraction reported with a vertex hit");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_frac <= pei_pkg::FRAC_ONE)
        else $error("fraction above one");

endmodule

bind polyline_edge_intersect pei_checker u_pei_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_frac      (o_out.cut_fraction),
    .i_start_hit (o_out.start_vertex_hit),
    .i_end_hit   (o_out.end_vertex_hit)
);
